FILE: sv/psfb_pkg.sv
// Package for the point set box fit block.
// Types, widths and register codes shared by the interfaces and modules.
package psfb_pkg;

  localparam int COORD_W  = 16;
  localparam int CANVAS_W = 13;
  localparam int MARGIN_W = 12;
  localparam int QUOT_W   = 13;
  localparam int PROD_W   = COORD_W + CANVAS_W;
  localparam int STEP_W   = $clog2(QUOT_W);
  localparam int CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] CFG_CANVAS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_MARGIN = 1'b1;

  localparam logic [CANVAS_W-1:0] CANVAS_RESET = 13'd256;
  localparam logic [MARGIN_W-1:0] MARGIN_RESET = 12'd0;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_SETUP,
    ST_READ,
    ST_START,
    ST_DIV,
    ST_PUSH
  } fit_state_t;

  typedef enum logic [1:0] {
    DIV_IDLE,
    DIV_MUL,
    DIV_RUN
  } div_phase_t;

endpackage

FILE: sv/psfb_if.sv
// Valid/ready channels for input points and fitted points.
// Depends on psfb_pkg for coordinate width.
interface psfb_in_if;
  import psfb_pkg::*;
  logic                       valid;
  logic                       ready;
  logic signed [COORD_W-1:0]  point_x;
  logic signed [COORD_W-1:0]  point_y;
  logic                       final_point;
  modport source (output valid, point_x, point_y, final_point, input ready);
  modport sink   (input valid, point_x, point_y, final_point, output ready);
endinterface

interface psfb_out_if;
  import psfb_pkg::*;
  logic                       valid;
  logic                       ready;
  logic signed [COORD_W-1:0]  fitted_x;
  logic signed [COORD_W-1:0]  fitted_y;
  logic                       run_end;
  modport source (output valid, fitted_x, fitted_y, run_end, input ready);
  modport sink   (input valid, fitted_x, fitted_y, run_end, output ready);
endinterface

FILE: sv/psfb_store.sv
// Point memory: one write port, one read port, registered read data.
// Each entry holds an x,y pair; depends on psfb_pkg for coordinate width.
module psfb_store #(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  logic                       clk,
  input  logic                       we,
  input  logic [AW-1:0]              waddr,
  input  logic [2*psfb_pkg::COORD_W-1:0] wdata,
  input  logic                       re,
  input  logic [AW-1:0]              raddr,
  output logic [2*psfb_pkg::COORD_W-1:0] rdata
);
  import psfb_pkg::*;

  logic [2*COORD_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: sv/psfb_div.sv
// Scale unit: registered multiply of offset by box, then radix-2 restoring
// division by span, one quotient bit per cycle. Depends on psfb_pkg.
module psfb_div (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [psfb_pkg::COORD_W-1:0]  offset,
  input  logic [psfb_pkg::QUOT_W-1:0]   box,
  input  logic [psfb_pkg::COORD_W-1:0]  span,
  output logic                         busy,
  output logic [psfb_pkg::QUOT_W-1:0]   quot
);
  import psfb_pkg::*;

  div_phase_t          phase, phase_next;
  logic [PROD_W-1:0]   prod;
  logic [COORD_W-1:0]  span_r;
  logic [COORD_W-1:0]  rem;
  logic [QUOT_W-1:0]   qsr;
  logic [STEP_W-1:0]   step;
  logic [COORD_W+1:0]  diff;
  logic                ge;
  logic [COORD_W-1:0]  rem_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= DIV_IDLE;
    end else begin
      phase <= phase_next;
    end
  end

  always_comb begin
    phase_next = phase;
    case (phase)
      DIV_IDLE: if (start) phase_next = DIV_MUL;
      DIV_MUL:  phase_next = DIV_RUN;
      DIV_RUN:  if (step == STEP_W'(QUOT_W - 1)) phase_next = DIV_IDLE;
      default:  phase_next = DIV_IDLE;
    endcase
  end

  always_comb begin
    diff     = {1'b0, rem, qsr[QUOT_W-1]} - {2'b00, span_r};
    ge       = !diff[COORD_W+1];
    rem_next = ge ? diff[COORD_W-1:0] : {rem[COORD_W-2:0], qsr[QUOT_W-1]};
  end

  always_ff @(posedge clk) begin
    if (start && phase == DIV_IDLE) begin
      prod   <= PROD_W'(offset * box);
      span_r <= span;
    end
    if (phase == DIV_MUL) begin
      rem  <= prod[PROD_W-1:QUOT_W];
      qsr  <= prod[QUOT_W-1:0];
      step <= '0;
    end else if (phase == DIV_RUN) begin
      rem  <= rem_next;
      qsr  <= {qsr[QUOT_W-2:0], ge};
      step <= step + STEP_W'(1);
    end
  end

  assign busy = (phase != DIV_IDLE);
  assign quot = qsr;

endmodule

FILE: sv/point_set_fit_to_box_top.sv
// Top level of the point set box fit block: control, bounding box, output.
// Depends on psfb_pkg, psfb_if, psfb_store and psfb_div.
//
//   channel   dir   handshake           payload
//   points    in    valid/ready         point_x, point_y, final_point
//   fitted    out   valid/ready         fitted_x, fitted_y, run_end
//   cfg       in    cfg_we (no wait)    cfg_index, cfg_data
//
// Load takes one point per cycle while no emit pass runs. A final point leads
// to a setup state, then each fitted point goes through memory read, multiply
// and 13 divider quotient steps; a single stored point skips the divider.
// Reset clears control and config only; the point memory needs no clearing.
// A stalled output holds the emit pass; loading resumes once the last item
// sits in the output register.
module point_set_fit_to_box_top #(
  parameter int MAX_POINTS = 64
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [psfb_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [psfb_pkg::CANVAS_W-1:0]     cfg_data,
  psfb_in_if.sink                           points,
  psfb_out_if.source                        fitted
);
  import psfb_pkg::*;

  localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int CW = $clog2(MAX_POINTS + 1);

  fit_state_t                 state, state_next;
  logic [CANVAS_W-1:0]        canvas_size;
  logic [MARGIN_W-1:0]        border_margin;
  logic [CW-1:0]              count;
  logic signed [COORD_W-1:0]  low_x, high_x, low_y, high_y;
  logic [COORD_W-1:0]         span;
  logic [QUOT_W-1:0]          box;
  logic                       raw;
  logic [AW-1:0]              rd_idx;
  logic                       out_valid;

  logic                       in_acc, room, last;
  logic                       rd_en, div_start, out_load;
  logic [2*COORD_W-1:0]       rd_data;
  logic [COORD_W-1:0]         rd_x, rd_y, off_x, off_y;
  logic [QUOT_W-1:0]          quot_x, quot_y;
  logic                       busy_x, busy_y;
  logic [COORD_W-1:0]         w_x, w_y, span_next;
  logic signed [CANVAS_W+1:0] box_s;

  assign room   = (count < CW'(MAX_POINTS));
  assign in_acc = points.valid && points.ready;
  assign last   = ((CW'(rd_idx) + CW'(1)) == count);
  assign rd_x   = rd_data[2*COORD_W-1:COORD_W];
  assign rd_y   = rd_data[COORD_W-1:0];
  assign off_x  = COORD_W'(rd_x - low_x);
  assign off_y  = COORD_W'(rd_y - low_y);

  always_comb begin
    w_x = COORD_W'(high_x - low_x);
    w_y = COORD_W'(high_y - low_y);
    if (w_x == '0) w_x = COORD_W'(1);
    if (w_y == '0) w_y = COORD_W'(1);
    span_next = (w_x > w_y) ? w_x : w_y;
    box_s = $signed({2'b00, canvas_size}) - $signed({1'b0, border_margin, 1'b0});
  end

  psfb_store #(.DEPTH(MAX_POINTS), .AW(AW)) u_store (
    .clk   (clk),
    .we    (in_acc && room),
    .waddr (count[AW-1:0]),
    .wdata ({points.point_x, points.point_y}),
    .re    (rd_en),
    .raddr (rd_idx),
    .rdata (rd_data)
  );

  psfb_div u_div_x (
    .clk (clk), .rst (rst), .start (div_start), .offset (off_x),
    .box (box), .span (span), .busy (busy_x), .quot (quot_x)
  );

  psfb_div u_div_y (
    .clk (clk), .rst (rst), .start (div_start), .offset (off_y),
    .box (box), .span (span), .busy (busy_y), .quot (quot_y)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_LOAD;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next    = state;
    points.ready  = 1'b0;
    rd_en         = 1'b0;
    div_start     = 1'b0;
    out_load      = 1'b0;
    case (state)
      ST_LOAD: begin
        points.ready = 1'b1;
        if (points.valid && points.final_point) state_next = ST_SETUP;
      end
      ST_SETUP: state_next = ST_READ;
      ST_READ: begin
        rd_en      = 1'b1;
        state_next = ST_START;
      end
      ST_START: begin
        div_start  = !raw;
        state_next = raw ? ST_PUSH : ST_DIV;
      end
      ST_DIV: if (!busy_x) state_next = ST_PUSH;
      ST_PUSH: begin
        out_load = !out_valid || fitted.ready;
        if (out_load) state_next = last ? ST_LOAD : ST_READ;
      end
      default: state_next = ST_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      canvas_size   <= CANVAS_RESET;
      border_margin <= MARGIN_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_CANVAS: canvas_size   <= cfg_data;
        CFG_MARGIN: border_margin <= cfg_data[MARGIN_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (in_acc && room) begin
      count <= count + CW'(1);
    end else if (out_load && last) begin
      count <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && room) begin
      if (count == '0) begin
        low_x  <= points.point_x;
        high_x <= points.point_x;
        low_y  <= points.point_y;
        high_y <= points.point_y;
      end else begin
        if (points.point_x < low_x)  low_x  <= points.point_x;
        if (points.point_x > high_x) high_x <= points.point_x;
        if (points.point_y < low_y)  low_y  <= points.point_y;
        if (points.point_y > high_y) high_y <= points.point_y;
      end
    end
    if (state == ST_SETUP) begin
      span   <= span_next;
      box    <= box_s[CANVAS_W+1] ? '0 : box_s[QUOT_W-1:0];
      raw    <= (count < CW'(2));
      rd_idx <= '0;
    end else if (out_load) begin
      rd_idx <= rd_idx + AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (fitted.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      fitted.fitted_x <= raw ? rd_x
        : COORD_W'(QUOT_W'(border_margin) + quot_x) | COORD_W'(0);
      fitted.fitted_y <= raw ? rd_y
        : COORD_W'(QUOT_W'(border_margin) + quot_y) | COORD_W'(0);
      fitted.run_end  <= last;
    end
  end

  assign fitted.valid = out_valid;

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(MAX_POINTS))
    else $error("point count above capacity");

  a_div_lockstep: assert property (@(posedge clk) disable iff (rst)
    busy_x == busy_y)
    else $error("x and y dividers out of step");

  a_emit_nonempty: assert property (@(posedge clk) disable iff (rst)
    (state != ST_LOAD && state != ST_SETUP) |-> (CW'(rd_idx) < count))
    else $error("emit index beyond stored points");

  a_no_load_when_emit: assert property (@(posedge clk) disable iff (rst)
    (state != ST_LOAD) |-> !points.ready)
    else $error("input taken during emit pass");

endmodule

FILE: tb/sv/tb_top.sv
// Testbench for point_set_fit_to_box_top: drawings in, fitted points out.
// Depends on psfb_pkg, psfb_if and the RTL; a built-in predictor checks every item.
module tb_top;
  import psfb_pkg::*;

  localparam int STORE_DEPTH  = 64;
  localparam int HOLD_CYCLES  = 400;
  localparam int SETTLE_CYCLES = 40;
  localparam int STALL_LIMIT  = 4000;
  localparam int RANDOM_ITEMS = 160;
  localparam int PHASES       = 8;
  localparam int FULL_PHASE   = 3;
  localparam int TABLE_ROWS   = 18;
  localparam int FULL_DRAWING = STORE_DEPTH + 2;
  localparam int PHASE_ITEMS  = (RANDOM_ITEMS - FULL_DRAWING - TABLE_ROWS) / PHASES;
  localparam int PICK         = -1;
  localparam int PHASE_CANVAS [PHASES] = '{100, 1, 4096, 4096, 1, PICK, PICK, 256};
  localparam int PHASE_MARGIN [PHASES] = '{60, 0, 2048, 0, 2048, PICK, PICK, 0};

  typedef enum {SCATTER, CLUSTER, VERTICAL, STACKED} sketch_shape_t;

  typedef struct {
    int x;
    int y;
    bit last;
    bit pinned;
    int fx;
    int fy;
  } sketch_row_t;

  typedef struct {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    bit                 pinned;
    logic [COORD_W-1:0] fx;
    logic [COORD_W-1:0] fy;
  } held_point_t;

  typedef struct {
    logic [COORD_W-1:0] fx;
    logic [COORD_W-1:0] fy;
    logic               run_end;
  } fit_result_t;

  logic                 clk = 1'b0;
  logic                 rst;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CANVAS_W-1:0]  cfg_data;

  psfb_in_if  points_ch ();
  psfb_out_if fitted_ch ();

  point_set_fit_to_box_top #(
    .MAX_POINTS(STORE_DEPTH)
  ) i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .points    (points_ch),
    .fitted    (fitted_ch)
  );

  sketch_row_t sketch_rows [TABLE_ROWS] = '{
    '{-32768, 32767, 1, 1, -32768, 32767},
    '{32767, -32768, 1, 1, 32767, -32768},
    '{-32768, -32768, 0, 1, 0, 0},
    '{32767, 32767, 1, 1, 256, 256},
    '{7, -3, 0, 1, 0, 0},
    '{7, -3, 1, 1, 0, 0},
    '{100, 0, 0, 1, 0, 0},
    '{100, 50, 0, 1, 0, 128},
    '{100, 100, 1, 1, 0, 256},
    '{-5, 12, 0, 0, 0, 0},
    '{300, -40, 0, 0, 0, 0},
    '{-1000, 999, 0, 0, 0, 0},
    '{0, 0, 1, 0, 0, 0},
    '{0, 0, 0, 0, 0, 0},
    '{1000, 10, 0, 0, 0, 0},
    '{-1, -1, 1, 0, 0, 0},
    '{21845, -21846, 0, 1, 256, 0},
    '{-21846, 21845, 1, 1, 0, 256}
  };

  held_point_t         held_pts [$];
  fit_result_t         pending_fits [$];
  int                  lo_x, hi_x, lo_y, hi_y;
  logic [CANVAS_W-1:0] canvas_r = CANVAS_RESET;
  logic [MARGIN_W-1:0] margin_r = MARGIN_RESET;
  bit                  tx_gaps = 1'b1;
  bit                  rx_gaps = 1'b1;
  bit                  hold_req = 1'b0;
  int                  errors = 0;
  int                  points_sent = 0;
  int                  drawings_sent = 0;
  int                  fits_checked = 0;
  int                  stall_cycles = 0;

  always #5 clk = ~clk;

  function automatic logic [COORD_W-1:0] fit_coord(logic [COORD_W-1:0] v, int lo,
                                                   longint box, longint span);
    longint d;
    d = longint'($signed(v)) - lo;
    return COORD_W'(longint'(margin_r) + d * box / span);
  endfunction

  function automatic void emit_fits();
    longint      w, h, span, box;
    fit_result_t r;
    int          n;
    n = held_pts.size();
    w = hi_x - lo_x;
    if (w < 1) w = 1;
    h = hi_y - lo_y;
    if (h < 1) h = 1;
    span = (w > h) ? w : h;
    box = longint'(canvas_r) - 2 * longint'(margin_r);
    if (box < 0) box = 0;
    foreach (held_pts[i]) begin
      if (held_pts[i].pinned) begin
        r.fx = held_pts[i].fx;
        r.fy = held_pts[i].fy;
      end else if (n < 2) begin
        r.fx = held_pts[i].x;
        r.fy = held_pts[i].y;
      end else begin
        r.fx = fit_coord(held_pts[i].x, lo_x, box, span);
        r.fy = fit_coord(held_pts[i].y, lo_y, box, span);
      end
      r.run_end = (i == n - 1);
      pending_fits.push_back(r);
    end
    held_pts.delete();
  endfunction

  function automatic void take_point(logic [COORD_W-1:0] x, logic [COORD_W-1:0] y, bit last,
                                     bit pinned, logic [COORD_W-1:0] fx,
                                     logic [COORD_W-1:0] fy);
    held_point_t p;
    int          sx, sy;
    sx = $signed(x);
    sy = $signed(y);
    if (held_pts.size() < STORE_DEPTH) begin
      if (held_pts.size() == 0) begin
        lo_x = sx;
        hi_x = sx;
        lo_y = sy;
        hi_y = sy;
      end else begin
        if (sx < lo_x) lo_x = sx;
        if (sx > hi_x) hi_x = sx;
        if (sy < lo_y) lo_y = sy;
        if (sy > hi_y) hi_y = sy;
      end
      p.x = x;
      p.y = y;
      p.pinned = pinned;
      p.fx = fx;
      p.fy = fy;
      held_pts.push_back(p);
    end
    if (last) emit_fits();
  endfunction

  task automatic send_point(int x, int y, bit last, bit pinned = 1'b0, int fx = 0, int fy = 0);
    if (tx_gaps && $urandom_range(0, 3) == 0) begin
      points_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    points_ch.valid       <= 1'b1;
    points_ch.point_x     <= COORD_W'(x);
    points_ch.point_y     <= COORD_W'(y);
    points_ch.final_point <= last;
    @(posedge clk);
    while (!points_ch.ready) @(posedge clk);
    take_point(COORD_W'(x), COORD_W'(y), last, pinned, COORD_W'(fx), COORD_W'(fy));
    points_sent++;
    if (last) drawings_sent++;
  endtask

  task automatic send_drawing(int n_pts);
    sketch_shape_t shape;
    int            base_x, base_y, spread;
    shape  = sketch_shape_t'($urandom_range(0, 3));
    base_x = $urandom_range(0, 65535);
    base_y = $urandom_range(0, 65535);
    spread = 1 << $urandom_range(0, 12);
    for (int i = 0; i < n_pts; i++) begin
      case (shape)
        SCATTER: send_point($urandom_range(0, 65535), $urandom_range(0, 65535), i == n_pts - 1);
        CLUSTER: send_point(base_x + $urandom_range(0, spread), base_y + $urandom_range(0, spread),
                            i == n_pts - 1);
        VERTICAL: send_point(base_x, base_y + $urandom_range(0, spread), i == n_pts - 1);
        default: send_point(base_x, base_y, i == n_pts - 1);
      endcase
    end
  endtask

  task automatic set_canvas(int canvas, int margin);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_CANVAS;
    cfg_data  <= CANVAS_W'(canvas);
    @(posedge clk);
    canvas_r = CANVAS_W'(canvas);
    cfg_index <= CFG_MARGIN;
    cfg_data  <= CANVAS_W'(margin);
    @(posedge clk);
    margin_r = MARGIN_W'(margin);
    cfg_we <= 1'b0;
  endtask

  task automatic drain_fits();
    points_ch.valid <= 1'b0;
    while (pending_fits.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    fitted_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        fitted_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else if (rx_gaps && $urandom_range(0, 3) == 0) begin
        fitted_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 3)) @(posedge clk);
      end else begin
        fitted_ch.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin : check_fits
    fit_result_t want;
    if (!rst && fitted_ch.valid && fitted_ch.ready) begin
      if (pending_fits.size() == 0) begin
        $error("fitted item with nothing expected: x %0d y %0d run_end %0b",
               fitted_ch.fitted_x, fitted_ch.fitted_y, fitted_ch.run_end);
        errors++;
      end else begin
        want = pending_fits.pop_front();
        fits_checked++;
        if (fitted_ch.fitted_x !== want.fx) begin
          $error("fitted_x: expected %0d, got %0d", $signed(want.fx), fitted_ch.fitted_x);
          errors++;
        end
        if (fitted_ch.fitted_y !== want.fy) begin
          $error("fitted_y: expected %0d, got %0d", $signed(want.fy), fitted_ch.fitted_y);
          errors++;
        end
        if (fitted_ch.run_end !== want.run_end) begin
          $error("run_end: expected %0b, got %0b", want.run_end, fitted_ch.run_end);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (points_ch.valid && points_ch.ready) || (fitted_ch.valid && fitted_ch.ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= STALL_LIMIT) begin
      $display("stalled for %0d cycles with %0d fitted items outstanding",
               stall_cycles, pending_fits.size());
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    int canvas, margin, phase_items, n_pts;
    rst                   <= 1'b1;
    cfg_we                <= 1'b0;
    cfg_index             <= CFG_CANVAS;
    cfg_data              <= '0;
    points_ch.valid       <= 1'b0;
    points_ch.point_x     <= '0;
    points_ch.point_y     <= '0;
    points_ch.final_point <= 1'b0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    foreach (sketch_rows[i]) begin
      send_point(sketch_rows[i].x, sketch_rows[i].y, sketch_rows[i].last,
                 sketch_rows[i].pinned, sketch_rows[i].fx, sketch_rows[i].fy);
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      drain_fits();
      canvas = (PHASE_CANVAS[ph] == PICK) ? $urandom_range(1, 4096) : PHASE_CANVAS[ph];
      margin = (PHASE_MARGIN[ph] == PICK) ? $urandom_range(0, canvas / 2) : PHASE_MARGIN[ph];
      set_canvas(canvas, margin);
      tx_gaps = (ph < PHASES - 1) && ($urandom_range(0, 3) != 0);
      rx_gaps = (ph < PHASES - 1) && ($urandom_range(0, 3) != 0);
      phase_items = 0;
      if (ph == FULL_PHASE) begin
        hold_req = 1'b1;
        send_drawing(FULL_DRAWING);
      end
      while (phase_items < PHASE_ITEMS) begin
        n_pts = ($urandom_range(0, 4) == 0) ? $urandom_range(7, 16) : $urandom_range(1, 5);
        if (n_pts > PHASE_ITEMS - phase_items) n_pts = PHASE_ITEMS - phase_items;
        send_drawing(n_pts);
        phase_items += n_pts;
      end
    end

    drain_fits();
    if (pending_fits.size() != 0) begin
      $error("%0d fitted items never arrived", pending_fits.size());
      errors++;
    end
    $display("sent %0d points in %0d drawings over %0d canvas settings plus reset defaults",
             points_sent, drawings_sent, PHASES);
    $display("checked %0d fitted items, incl. full store, flat and zero/negative box cases",
             fits_checked);
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
